FILE: rtl/core/sterm_pkg.sv
// Shared types and constants for the two-line scrolling text terminal.
package sterm_pkg;

   // Characters held on the bottom display line.
   localparam int LINE_WIDTH = 16;
   localparam int CNT_W      = $clog2(LINE_WIDTH + 1);
   localparam int ADDR_W     = $clog2(LINE_WIDTH);

   // Fixed field widths of the display command beat.
   localparam int BYTE_W = 8;
   localparam int COL_W  = 4;

   // Carriage return scrolls the bottom line up.
   localparam logic [BYTE_W-1:0] CR_CODE = 8'd13;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_CURSOR = 2'd2
   } lcd_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_HOME,
      ST_REPLAY,
      ST_BOTTOM
   } seq_state_type;

   // One display command as it travels from the sequencer to the output stage.
   typedef struct packed {
      lcd_op_type          op;
      logic [COL_W-1:0]    column;
      logic                row;
      logic [BYTE_W-1:0]   char_code;
      logic                last;
   } beat_type;

endpackage

FILE: rtl/core/sterm_line_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sterm_line_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; read data is registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/sterm_seq.sv
// Command sequencer: stores typed characters and walks the scroll sequence.
module sterm_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [sterm_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                       req_stall,
   input  logic                       out_free,
   output logic                       beat_valid,
   output sterm_pkg::beat_type        beat
);
   import sterm_pkg::*;

   seq_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_inc;
   logic [CNT_W-1:0]  idx_inc;
   logic              accept;
   logic              is_cr;
   logic              wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;

   assign count_inc = count_ff + 1'b1;
   assign idx_inc   = idx_ff + 1'b1;
   assign accept    = (state_ff == ST_IDLE) && req_valid && out_free;
   assign is_cr     = (req_rx_byte == CR_CODE);

   // Bottom-line character store.
   sterm_line_ram #(
      .DEPTH (LINE_WIDTH),
      .WIDTH (BYTE_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_rx_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_cr) begin
                  state_in = ST_HOME;
               end else if (count_inc == CNT_W'(LINE_WIDTH)) begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            if (out_free) begin
               state_in = ST_HOME;
            end
         end
         ST_HOME: begin
            if (out_free) begin
               state_in = (count_ff == '0) ? ST_BOTTOM : ST_REPLAY;
            end
         end
         ST_REPLAY: begin
            if (out_free && (idx_inc == count_ff)) begin
               state_in = ST_BOTTOM;
            end
         end
         ST_BOTTOM: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs, RAM controls and counter updates.
   always_comb begin
      beat       = '0;
      beat.op    = OP_WRITE;
      beat_valid = 1'b0;
      req_stall  = 1'b1;
      wr_en      = 1'b0;
      count_in   = count_ff;
      idx_in     = idx_ff;
      rd_addr    = idx_ff[ADDR_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !out_free;
            if (accept) begin
               beat_valid = 1'b1;
               if (is_cr) begin
                  beat.op = OP_CLEAR;
               end else begin
                  wr_en          = 1'b1;
                  beat.op        = OP_WRITE;
                  beat.char_code = req_rx_byte;
                  beat.last      = (count_inc != CNT_W'(LINE_WIDTH));
                  count_in       = count_inc;
               end
            end
         end
         ST_CLEAR: begin
            beat.op    = OP_CLEAR;
            beat_valid = out_free;
         end
         ST_HOME: begin
            // Prefetch the first stored character while the cursor moves home.
            rd_addr    = '0;
            beat.op    = OP_CURSOR;
            beat_valid = out_free;
            if (out_free) begin
               idx_in = '0;
            end
         end
         ST_REPLAY: begin
            // Read data belongs to idx; on advance fetch the next entry.
            beat.op        = OP_WRITE;
            beat.char_code = rd_data;
            beat_valid     = out_free;
            if (out_free) begin
               idx_in  = idx_inc;
               rd_addr = idx_inc[ADDR_W-1:0];
            end
         end
         ST_BOTTOM: begin
            beat.op    = OP_CURSOR;
            beat.row   = 1'b1;
            beat.last  = 1'b1;
            beat_valid = out_free;
            if (out_free) begin
               count_in = '0;
            end
         end
         default: begin
            beat_valid = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

FILE: rtl/core/two_line_scrolling_text_terminal.sv
// Top level of the two-line scrolling text terminal.
//
// Each accepted byte turns into a run of display commands on the rsp channel,
// one command per cycle while rsp_stall is low; last_of_run marks the final
// command of the run. An ordinary byte is stored in a 16-entry line RAM and
// gives one write-character command. A carriage return, or the byte that
// fills the line, starts a scroll: clear, cursor home, a replay of the N
// stored characters read back from the line RAM, and cursor to the start of
// the bottom row. The replay streams the stored characters through the single
// read port of the line RAM, one character per cycle while the output
// register can take a beat. New bytes are stalled until the run is finished
// and the output register can take a new beat.
module two_line_scrolling_text_terminal (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sterm_pkg::BYTE_W-1:0]  req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_lcd_op,
   output logic [sterm_pkg::COL_W-1:0]   rsp_cursor_column,
   output logic                          rsp_cursor_row,
   output logic [sterm_pkg::BYTE_W-1:0]  rsp_char_code,
   output logic                          rsp_last_of_run
);
   import sterm_pkg::*;

   logic     out_free;
   logic     beat_valid;
   beat_type beat;
   logic     rsp_valid_ff, rsp_valid_in;
   beat_type rsp_beat_ff, rsp_beat_in;

   // The output register can take a beat when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   sterm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .out_free    (out_free),
      .beat_valid  (beat_valid),
      .beat        (beat)
   );

   // Output register next value.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (beat_valid) begin
         rsp_valid_in = 1'b1;
         rsp_beat_in  = beat;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_lcd_op        = rsp_beat_ff.op;
   assign rsp_cursor_column = rsp_beat_ff.column;
   assign rsp_cursor_row    = rsp_beat_ff.row;
   assign rsp_char_code     = rsp_beat_ff.char_code;
   assign rsp_last_of_run   = rsp_beat_ff.last;

   // Nothing is presented right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result beat valid after reset");

   // Every accepted byte produces a beat on the next cycle.
   a_accept_beat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid_ff)
      else $error("accepted byte produced no beat");

   // A clear screen always opens a scroll and never ends a run.
   a_clear_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_beat_ff.op == OP_CLEAR)) |-> !rsp_beat_ff.last)
      else $error("clear screen marked as last of run");

   // A move to the bottom row always ends the run.
   a_bottom_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_beat_ff.op == OP_CURSOR) && rsp_beat_ff.row)
      |-> rsp_beat_ff.last)
      else $error("bottom row cursor move not last of run");

endmodule
